/* rtl/core/multibyte_delimiter_splitter_macros.svh */
// ----------------------------------------------------------------------------
// multibyte delimiter splitter assertion macros
// short forms for the concurrent checks of the splitter checker
// ----------------------------------------------------------------------------
`ifndef MULTIBYTE_DELIMITER_SPLITTER_MACROS_SVH
`define MULTIBYTE_DELIMITER_SPLITTER_MACROS_SVH

// same-cycle implication, reset disables
`define MDS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset disables
`define MDS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/mds_pkg.sv */
// ----------------------------------------------------------------------------
// mds_pkg
// types, sizes and helpers shared by the multibyte delimiter splitter
// ----------------------------------------------------------------------------
package mds_pkg;

	localparam int MAX_DELIM_BYTES = 8;
	localparam int DLEN_W          = 4;
	localparam int DBYTES_W        = 64;
	localparam int CFG_IDX_W       = 1;
	localparam int FILL_W          = $clog2(MAX_DELIM_BYTES + 1);
	localparam int WIN_BITS        = MAX_DELIM_BYTES * 8;
	// shifted-out byte, window flush and one field end
	localparam int BURST_MAX       = MAX_DELIM_BYTES + 2;
	localparam int QUEUE_DEPTH     = BURST_MAX + 1;
	localparam int CNT_W           = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CFG_IDX_W-1:0] REG_DELIM_LENGTH = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_DELIM_BYTES  = CFG_IDX_W'(1);

	localparam logic [DLEN_W-1:0]   DLEN_RESET   = DLEN_W'(1);
	localparam logic [DBYTES_W-1:0] DBYTES_RESET = DBYTES_W'(32);

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_of_line;
	} in_item_t;

	typedef struct packed {
		logic       byte_valid;
		logic [7:0] out_byte;
		logic       field_end;
		logic       line_end;
	} out_item_t;

	typedef logic [MAX_DELIM_BYTES-1:0][7:0] win_t;
	typedef out_item_t [BURST_MAX-1:0] burst_t;

	typedef struct packed {
		burst_t            results;
		logic [CNT_W-1:0]  count;
		win_t              window;
		logic [FILL_W-1:0] fill;
	} step_t;

	function automatic out_item_t mk_data(input logic [7:0] b);
		out_item_t r;
		r.byte_valid = 1'b1;
		r.out_byte   = b;
		r.field_end  = 1'b0;
		r.line_end   = 1'b0;
		return r;
	endfunction

	function automatic out_item_t mk_fend(input logic le);
		out_item_t r;
		r.byte_valid = 1'b0;
		r.out_byte   = 8'h00;
		r.field_end  = 1'b1;
		r.line_end   = le;
		return r;
	endfunction

endpackage

/* rtl/core/multibyte_delimiter_splitter.sv */
// ----------------------------------------------------------------------------
// multibyte_delimiter_splitter
// splits a byte stream into fields on a delimiter of one to eight bytes
//
//   channel  | direction | payload       | transfer when
//   in       | sink      | in_item_t     | in_valid && !in_stall
//   out      | source    | out_item_t    | out_valid && !out_stall
//   cfg      | sink      | index, data   | cfg_we
//
// each byte is held in the input register, then its results enter a
// shift queue that drives one result per cycle on the output unless out_stall
// one byte per cycle while each byte gives at most one result and the output
// does not stall; a line end gives up to ten results, and the input stalls
// while more than one result waits in the queue
// reset clears the counters and valid flags; window bytes are not reset
// ----------------------------------------------------------------------------
module multibyte_delimiter_splitter (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  mds_pkg::in_item_t                in_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output mds_pkg::out_item_t               out_data,
	input  logic                             cfg_we,
	input  logic [mds_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mds_pkg::DBYTES_W-1:0]     cfg_data
);

	logic                             valid_s1;
	mds_pkg::in_item_t                item_s1;
	logic [mds_pkg::DLEN_W-1:0]       dlen_q;
	logic [mds_pkg::DBYTES_W-1:0]     dbytes_q;
	mds_pkg::win_t                    win_q;
	logic [mds_pkg::FILL_W-1:0]       fill_q;
	mds_pkg::out_item_t               res_q [mds_pkg::QUEUE_DEPTH];
	mds_pkg::out_item_t               res_d [mds_pkg::QUEUE_DEPTH];
	logic [mds_pkg::CNT_W-1:0]        cnt_q;
	logic [mds_pkg::CNT_W-1:0]        cnt_d;
	mds_pkg::step_t                   step;
	logic                             go;
	logic                             pop;
	logic                             keep;
	logic                             in_xfer;

	mds_step u_step (
		.item         (item_s1),
		.window       (win_q),
		.fill         (fill_q),
		.delim_length (dlen_q),
		.delim_bytes  (dbytes_q),
		.step         (step)
	);

	// the held byte moves on once at most one result is queued
	assign go       = valid_s1 && (cnt_q <= mds_pkg::CNT_W'(1));
	assign in_stall = valid_s1 && !go;
	assign in_xfer  = in_valid && !in_stall;
	assign out_valid = (cnt_q != '0);
	assign out_data  = res_q[0];
	assign pop       = out_valid && !out_stall;
	assign keep      = go && (cnt_q == mds_pkg::CNT_W'(1)) && !pop;

	always_comb begin
		for (int j = 0; j < mds_pkg::QUEUE_DEPTH; j++) begin
			if (go) begin
				if (keep) begin
					if (j == 0) begin
						res_d[j] = res_q[0];
					end else begin
						res_d[j] = (j - 1 < mds_pkg::BURST_MAX) ? step.results[j-1] : '0;
					end
				end else begin
					res_d[j] = (j < mds_pkg::BURST_MAX) ? step.results[j] : '0;
				end
			end else if (pop) begin
				res_d[j] = (j < mds_pkg::QUEUE_DEPTH - 1) ? res_q[j+1] : '0;
			end else begin
				res_d[j] = res_q[j];
			end
		end
		cnt_d = cnt_q - mds_pkg::CNT_W'(pop) + (go ? step.count : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cnt_q    <= '0;
			fill_q   <= '0;
			dlen_q   <= mds_pkg::DLEN_RESET;
			dbytes_q <= mds_pkg::DBYTES_RESET;
		end else begin
			if (in_xfer) begin
				valid_s1 <= 1'b1;
			end else if (go) begin
				valid_s1 <= 1'b0;
			end
			cnt_q <= cnt_d;
			if (cfg_we) begin
				fill_q <= '0;
				unique case (cfg_index)
					mds_pkg::REG_DELIM_LENGTH: begin
						dlen_q <= cfg_data[mds_pkg::DLEN_W-1:0];
					end
					mds_pkg::REG_DELIM_BYTES: begin
						dbytes_q <= cfg_data;
					end
				endcase
			end else if (go) begin
				fill_q <= step.fill;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_s1 <= in_data;
		end
		if (go) begin
			win_q <= step.window;
		end
		for (int j = 0; j < mds_pkg::QUEUE_DEPTH; j++) begin
			res_q[j] <= res_d[j];
		end
	end

endmodule

/* rtl/core/mds_step.sv */
// ----------------------------------------------------------------------------
// mds_step
// per-byte window update, delimiter compare and result burst build
// ----------------------------------------------------------------------------
module mds_step (
	input  mds_pkg::in_item_t                item,
	input  mds_pkg::win_t                    window,
	input  logic [mds_pkg::FILL_W-1:0]       fill,
	input  logic [mds_pkg::DLEN_W-1:0]       delim_length,
	input  logic [mds_pkg::DBYTES_W-1:0]     delim_bytes,
	output mds_pkg::step_t                   step
);

	logic [mds_pkg::FILL_W-1:0] len;
	logic [mds_pkg::FILL_W-1:0] f;
	logic [mds_pkg::FILL_W-1:0] f2;
	logic [mds_pkg::FILL_W-1:0] f3;
	logic                       full;
	logic                       hit;
	mds_pkg::win_t              base;
	mds_pkg::win_t              w2;
	mds_pkg::win_t              dwin;
	mds_pkg::out_item_t [mds_pkg::MAX_DELIM_BYTES:0] tail;

	always_comb begin
		// zero length acts as one, long lengths saturate
		if (delim_length == '0) begin
			len = mds_pkg::FILL_W'(1);
		end else if (int'(delim_length) > mds_pkg::MAX_DELIM_BYTES) begin
			len = mds_pkg::FILL_W'(mds_pkg::MAX_DELIM_BYTES);
		end else begin
			len = mds_pkg::FILL_W'(delim_length);
		end

		f    = (fill > len) ? len : fill;
		full = (f == len);
		// full window drops its oldest byte
		base = full ? mds_pkg::win_t'(window >> 8) : window;
		f2   = full ? (len - mds_pkg::FILL_W'(1)) : f;
		for (int i = 0; i < mds_pkg::MAX_DELIM_BYTES; i++) begin
			w2[i] = (i == int'(f2)) ? item.data_byte : base[i];
		end
		f3 = f2 + mds_pkg::FILL_W'(1);

		dwin = mds_pkg::WIN_BITS'(delim_bytes);
		hit  = (f3 == len);
		for (int i = 0; i < mds_pkg::MAX_DELIM_BYTES; i++) begin
			if (i < int'(len) && w2[i] != dwin[i]) begin
				hit = 1'b0;
			end
		end

		// results after the shifted-out byte
		for (int k = 0; k <= mds_pkg::MAX_DELIM_BYTES; k++) begin
			tail[k] = '0;
			if (hit) begin
				if (k == 0) begin
					tail[k] = mds_pkg::mk_fend(item.last_of_line);
				end
			end else if (item.last_of_line) begin
				if (k < int'(f3) && k < mds_pkg::MAX_DELIM_BYTES) begin
					tail[k] = mds_pkg::mk_data(w2[k]);
				end else if (k == int'(f3)) begin
					tail[k] = mds_pkg::mk_fend(1'b1);
				end
			end
		end

		for (int j = 0; j < mds_pkg::BURST_MAX; j++) begin
			if (full) begin
				step.results[j] = (j == 0) ? mds_pkg::mk_data(window[0]) : tail[j-1];
			end else begin
				step.results[j] = (j <= mds_pkg::MAX_DELIM_BYTES) ? tail[j] : '0;
			end
		end

		step.count = mds_pkg::CNT_W'(full);
		if (hit) begin
			step.count = step.count + mds_pkg::CNT_W'(1);
		end else if (item.last_of_line) begin
			step.count = step.count + mds_pkg::CNT_W'(f3) + mds_pkg::CNT_W'(1);
		end

		step.window = w2;
		step.fill   = (hit || item.last_of_line) ? '0 : f3;
	end

endmodule

/* rtl/core/mds_checker.sv */
// ----------------------------------------------------------------------------
// mds_checker
// port-level checks for the multibyte delimiter splitter
// ----------------------------------------------------------------------------
`include "multibyte_delimiter_splitter_macros.svh"

module mds_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_stall,
	input  logic               out_valid,
	input  logic               out_stall,
	input  mds_pkg::out_item_t out_data
);

	// a stalled result holds
	`MDS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

	// input only backs up behind queued results
	`MDS_ASSERT_SAME(a_stall_has_results, clk, arst_n, in_stall, out_valid, "input stalled with no result waiting")

	// each result is either a data byte or a field end
	`MDS_ASSERT_SAME(a_one_kind, clk, arst_n, out_valid, out_data.byte_valid != out_data.field_end, "result is neither or both of data and field end")

	// line end always rides on a field end
	`MDS_ASSERT_SAME(a_line_end_on_field, clk, arst_n, out_valid && out_data.line_end, out_data.field_end && !out_data.byte_valid, "line end without field end")

endmodule

bind multibyte_delimiter_splitter mds_checker u_mds_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
